>>> src/assert_macros.svh
// concurrent assertion helpers clocked on clk with active-low reset rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define ASSERT_NEVER(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, prop)

`define ASSERT_NEVER(label, prop)

`endif

`endif

>>> src/owbm_pkg.sv
package owbm_pkg;

    localparam logic [2:0] CMD_TICK       = 3'd0;
    localparam logic [2:0] CMD_RESET      = 3'd1;
    localparam logic [2:0] CMD_WRITE_BYTE = 3'd2;
    localparam logic [2:0] CMD_READ_BYTE  = 3'd3;
    localparam logic [2:0] CMD_WRITE_BIT  = 3'd4;
    localparam logic [2:0] CMD_READ_BIT   = 3'd5;

    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    localparam logic [8:0] RST_LOW_LAST  = 9'd479;
    localparam logic [8:0] RST_WAIT_LAST = 9'd69;
    localparam logic [8:0] RST_TAIL_LAST = 9'd409;
    localparam logic [8:0] WR_ONE_LOW    = 9'd10;
    localparam logic [8:0] WR_ZERO_LOW   = 9'd65;
    localparam logic [8:0] WR_SLOT_LAST  = 9'd69;
    localparam logic [8:0] RD_LOW_TICKS  = 9'd3;
    localparam logic [8:0] RD_SAMPLE     = 9'd13;
    localparam logic [8:0] RD_SLOT_LAST  = 9'd62;

    localparam logic [1:0] PH_LOW  = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_TAIL = 2'd2;

    typedef enum logic [5:0] {
        OP_IDLE       = 6'b000001,
        OP_RESET      = 6'b000010,
        OP_WRITE_BYTE = 6'b000100,
        OP_READ_BYTE  = 6'b001000,
        OP_WRITE_BIT  = 6'b010000,
        OP_READ_BIT   = 6'b100000
    } op_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] rx_data;
        logic       cmd_rejected;
    } res_t;

endpackage

>>> src/owbm_core.sv
module owbm_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [2:0]          cmd,
    input  logic [7:0]          tx_data,
    input  logic                bus_level,
    output owbm_pkg::res_t      res
);
    import owbm_pkg::*;

    op_t        op_reg, op_next;
    logic [1:0] phase_reg, phase_next;
    logic [8:0] timer_reg, timer_next;
    logic [3:0] bits_reg, bits_next;
    logic [7:0] shift_reg, shift_next;
    logic       pres_reg, pres_next;
    logic [7:0] rdres_reg, rdres_next;

    always_comb
    begin
        logic [8:0] low_len;
        logic       finish;
        op_next    = op_reg;
        phase_next = phase_reg;
        timer_next = timer_reg;
        bits_next  = bits_reg;
        shift_next = shift_reg;
        pres_next  = pres_reg;
        rdres_next = rdres_reg;
        finish     = 1'b0;
        low_len    = WR_ZERO_LOW;
        res        = '0;

        // command decode
        if (op_reg == OP_IDLE)
        begin
            if (cmd inside {[CMD_RESET:CMD_READ_BIT]})
            begin
                phase_next = PH_LOW;
                timer_next = '0;
                case (cmd)
                    CMD_RESET:
                    begin
                        op_next    = OP_RESET;
                        shift_next = '0;
                        bits_next  = 4'd1;
                    end
                    CMD_WRITE_BYTE:
                    begin
                        op_next    = OP_WRITE_BYTE;
                        shift_next = tx_data;
                        bits_next  = 4'd8;
                    end
                    CMD_READ_BYTE:
                    begin
                        op_next    = OP_READ_BYTE;
                        shift_next = '0;
                        bits_next  = 4'd8;
                    end
                    CMD_WRITE_BIT:
                    begin
                        op_next    = OP_WRITE_BIT;
                        shift_next = {7'd0, tx_data[0]};
                        bits_next  = 4'd1;
                    end
                    default:
                    begin
                        op_next    = OP_READ_BIT;
                        shift_next = '0;
                        bits_next  = 4'd1;
                    end
                endcase
            end
        end
        else if (cmd != CMD_TICK)
        begin
            res.cmd_rejected = 1'b1;
        end

        // one tick of the active operation
        case (op_next)
            OP_RESET:
            begin
                res.busy_res = 1'b1;
                case (phase_next)
                    PH_LOW:
                    begin
                        res.drive_low = 1'b1;
                        if (timer_next >= RST_LOW_LAST)
                        begin
                            phase_next = PH_WAIT;
                            timer_next = '0;
                        end
                        else
                        begin
                            timer_next = timer_next + 9'd1;
                        end
                    end
                    PH_WAIT:
                    begin
                        if (timer_next >= RST_WAIT_LAST)
                        begin
                            phase_next = PH_TAIL;
                            timer_next = '0;
                        end
                        else
                        begin
                            timer_next = timer_next + 9'd1;
                        end
                    end
                    default:
                    begin
                        if (timer_next == 9'd0)
                        begin
                            pres_next = ~bus_level;
                        end
                        if (timer_next >= RST_TAIL_LAST)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            timer_next = timer_next + 9'd1;
                        end
                    end
                endcase
            end
            OP_WRITE_BYTE, OP_WRITE_BIT:
            begin
                low_len       = shift_next[0] ? WR_ONE_LOW : WR_ZERO_LOW;
                res.busy_res  = 1'b1;
                res.drive_low = (timer_next < low_len);
                if (timer_next >= WR_SLOT_LAST)
                begin
                    shift_next = {1'b0, shift_next[7:1]};
                    bits_next  = bits_next - 4'd1;
                    timer_next = '0;
                    finish     = (bits_next == 4'd0);
                end
                else
                begin
                    timer_next = timer_next + 9'd1;
                end
            end
            OP_READ_BYTE, OP_READ_BIT:
            begin
                res.busy_res  = 1'b1;
                res.drive_low = (timer_next < RD_LOW_TICKS);
                if (timer_next == RD_SAMPLE)
                begin
                    shift_next = {bus_level, shift_next[7:1]};
                end
                if (timer_next >= RD_SLOT_LAST)
                begin
                    bits_next  = bits_next - 4'd1;
                    timer_next = '0;
                    if (bits_next == 4'd0)
                    begin
                        rdres_next = (op_next == OP_READ_BYTE) ? shift_next
                                                               : {7'd0, shift_next[7]};
                        finish     = 1'b1;
                    end
                end
                else
                begin
                    timer_next = timer_next + 9'd1;
                end
            end
            default:
            begin
                op_next = OP_IDLE;
            end
        endcase

        if (finish)
        begin
            res.done_res = 1'b1;
            op_next      = OP_IDLE;
            phase_next   = PH_LOW;
            timer_next   = '0;
            bits_next    = '0;
        end

        res.presence = pres_next;
        res.rx_data  = rdres_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg    <= OP_IDLE;
            phase_reg <= PH_LOW;
            timer_reg <= '0;
            bits_reg  <= '0;
            shift_reg <= '0;
            pres_reg  <= 1'b0;
            rdres_reg <= '0;
        end
        else if (step)
        begin
            op_reg    <= op_next;
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            bits_reg  <= bits_next;
            shift_reg <= shift_next;
            pres_reg  <= pres_next;
            rdres_reg <= rdres_next;
        end
    end

endmodule

>>> src/owbm_out_reg.sv
module owbm_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  owbm_pkg::res_t      in_res,
    output logic                out_valid,
    input  logic                out_ready,
    output owbm_pkg::res_t      out_res
);
    import owbm_pkg::*;

    logic valid_reg;
    res_t res_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            res_reg <= in_res;
        end
    end

endmodule

>>> src/one_wire_bus_master.sv
// 1-wire bus master, one input word per one-microsecond tick
// slave side s_*: each word is one tick and may carry a command
//   (tick only, reset with presence detect, write byte, read byte,
//   write bit, read bit); commands are taken only while idle
// master side m_*: exactly one result word per input word, with the line
//   drive, busy, done, presence, last read data and a rejected flag
// latency: the result of a word is valid the cycle after it is accepted
// throughput: one word per cycle; the state update and result are one
//   registered pass through the slot sequencer, and the output register
//   lets the next word in during the cycle the held result is taken
// when the receiver stalls, the held result keeps s_tready low and the
//   sequencer does not advance, so no tick is lost or repeated
// reset: sequencer idle, presence and read data zero, output empty;
//   operations last 960 ticks (reset), 70 per written bit, 63 per read bit
module one_wire_bus_master (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cmd[2:0], tx_data[10:3], bus_level[11], zero fill
    input  logic [owbm_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // drive_low[0], busy_res[1], done_res[2], presence[3], rx_data[11:4],
    // cmd_rejected[12], zero fill
    output logic [owbm_pkg::M_DATA_W-1:0] m_tdata
);
    import owbm_pkg::*;

`include "assert_macros.svh"

    logic step;
    res_t core_res;
    res_t out_res;

    assign step = s_tvalid && s_tready;

    owbm_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .cmd       (s_tdata[2:0]),
        .tx_data   (s_tdata[10:3]),
        .bus_level (s_tdata[11]),
        .res       (core_res)
    );

    owbm_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_res    (core_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {3'd0, out_res.cmd_rejected, out_res.rx_data, out_res.presence,
                      out_res.done_res, out_res.busy_res, out_res.drive_low};

    `ASSERT_CLK(a_accept_gives_result, step |=> m_tvalid)
    `ASSERT_NEVER(a_done_without_busy, m_tvalid && out_res.done_res && !out_res.busy_res)
    `ASSERT_NEVER(a_drive_while_idle, m_tvalid && out_res.drive_low && !out_res.busy_res)
    `ASSERT_NEVER(a_reject_while_idle, m_tvalid && out_res.cmd_rejected && !out_res.busy_res)

endmodule
